[hdl/assert_macros.svh]
// Assertion macros shared by the sorter modules.
// Holds no logic; included by files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hdl/drisort_pkg.sv]
// Types and codes shared by the sorter controller and datapath.
// No dependencies.
package drisort_pkg;
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_FETCH = 2'd1;
   localparam logic [1:0] ACT_NEW   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_SORT_KEY,
      ST_SORT_WR,
      ST_SORT_PUT,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_NEW,
      CMD_CLEAR_STEP,
      CMD_SORT_INIT,
      CMD_SORT_READ,
      CMD_SORT_CMP,
      CMD_SORT_SHIFT,
      CMD_SORT_PUT,
      CMD_EMIT_READ,
      CMD_EMIT_CHECK,
      CMD_EMIT_DONE
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic sort_more;
      logic sort_done;
      logic shift_go;
      logic emit_hit;
      logic emit_empty;
      logic ranks_ready;
   } status_type;
endpackage

[hdl/dual_rank_interleave_sorter.sv]
// Top level of the dual-rank interleave sorter.
// Depends on drisort_pkg, drisort_ctrl and drisort_dp.
//
// After reset and after each new-table beat a clearing pass runs over the used map,
// during which no beat is accepted. The first fetch of a table runs two insertion
// sorts through the rank memories, one per ranking. Each fetch then walks the two
// rankings in turn until it finds an unused row or reaches their end.
// No beat is accepted while a result waits on rsp_ready.
module dual_rank_interleave_sorter import drisort_pkg::*; #(
   parameter int MAX_ROWS   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic signed [31:0] req_flux_value,
   input  logic signed [31:0] req_background_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_row_index,
   output logic        rsp_final_row,
   output logic        rsp_exhausted,
   output logic        rsp_overflowed
);
   logic       asc_ff;
   status_type stat;
   cmd_type    cmd;

   always_ff @(posedge clock) begin
      if (reset) asc_ff <= 1'b0;
      else if (csr_write_enable) asc_ff <= csr_write_data;
   end

   drisort_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action,
      .rsp_valid, .rsp_ready, .stat, .cmd
   );

   drisort_dp #(.MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock, .reset, .cmd,
      .cfg_ascending(asc_ff),
      .flux_in(VALUE_BITS'(req_flux_value)),
      .back_in(VALUE_BITS'(req_background_value)),
      .stat,
      .row_index(rsp_row_index),
      .final_row(rsp_final_row),
      .exhausted(rsp_exhausted),
      .overflowed(rsp_overflowed)
   );
endmodule

[hdl/drisort_ctrl.sv]
// Sequencer for the sorter: load, clear sweep, insertion sort, emit walk.
// Depends on drisort_pkg and assert_macros.svh.
`include "assert_macros.svh"
module drisort_ctrl import drisort_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type stat,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = CMD_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               case (req_action)
                  ACT_LOAD: cmd = CMD_LOAD;
                  ACT_NEW: begin
                     cmd      = CMD_NEW;
                     state_in = ST_CLEAR;
                  end
                  ACT_FETCH: begin
                     if (stat.ranks_ready) begin
                        cmd      = CMD_EMIT_READ;
                        state_in = ST_EMIT_RD;
                     end else begin
                        cmd      = CMD_SORT_INIT;
                        state_in = ST_SORT_RD;
                     end
                  end
                  default: cmd = CMD_NONE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd = CMD_CLEAR_STEP;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_SORT_RD: begin
            if (stat.sort_done) begin
               cmd      = CMD_EMIT_READ;
               state_in = ST_EMIT_RD;
            end else begin
               cmd      = CMD_SORT_READ;
               state_in = ST_SORT_CMP;
            end
         end
         ST_SORT_CMP: begin
            cmd      = CMD_SORT_CMP;
            state_in = ST_SORT_KEY;
         end
         ST_SORT_KEY: begin
            state_in = ST_SORT_WR;
         end
         ST_SORT_WR: begin
            if (stat.shift_go) begin
               cmd      = CMD_SORT_SHIFT;
               state_in = ST_SORT_CMP;
            end else begin
               cmd      = CMD_SORT_PUT;
               state_in = ST_SORT_RD;
            end
         end
         ST_EMIT_RD: begin
            cmd      = CMD_EMIT_CHECK;
            state_in = ST_EMIT_CHK;
         end
         ST_EMIT_CHK: begin
            if (stat.emit_hit || stat.emit_empty) begin
               cmd      = CMD_EMIT_DONE;
               state_in = ST_RESP;
            end else begin
               cmd      = CMD_EMIT_READ;
               state_in = ST_EMIT_RD;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `CHECK_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE, "ready outside idle")
   `CHECK_NEXT(a_resp_valid, clock, reset, state_ff == ST_RESP, rsp_valid_ff, "response lost")
   `CHECK_IMPL(a_no_double, clock, reset, state_ff == ST_RESP, !rsp_valid_ff || rsp_ready,
               "response overwritten")
endmodule

[hdl/drisort_dp.sv]
// Datapath: row stores, the two rankings, the used map and emit counters.
// Depends on drisort_pkg and assert_macros.svh.
`include "assert_macros.svh"
module drisort_dp import drisort_pkg::*; #(
   parameter int MAX_ROWS   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   input  logic                         cfg_ascending,
   input  logic signed [VALUE_BITS-1:0] flux_in,
   input  logic signed [VALUE_BITS-1:0] back_in,
   output status_type                   stat,
   output logic [9:0]                   row_index,
   output logic                         final_row,
   output logic                         exhausted,
   output logic                         overflowed
);
   localparam int AW = $clog2(MAX_ROWS);
   localparam int CW = AW + 1;
   localparam int KW = VALUE_BITS + 1;
   localparam logic [CW-1:0] CAP = CW'(MAX_ROWS);

   // Memories; pass 0 sorts flux, pass 1 sorts the sum
   logic signed [KW-1:0] flux_mem [MAX_ROWS];
   logic signed [KW-1:0] sum_mem  [MAX_ROWS];
   logic [AW-1:0]        frank_mem [MAX_ROWS];
   logic [AW-1:0]        srank_mem [MAX_ROWS];
   logic                 used_mem  [MAX_ROWS];

   logic [CW-1:0] count_ff, pos_ff, emitted_ff, i_ff, j_ff;
   logic          phase_ff, ready_ff, ovf_ff, pass_ff, asc_ff, live_ff;
   logic [AW-1:0] clr_ff;
   logic          clr_done_ff;
   logic signed [KW-1:0] key_ff;
   logic [AW-1:0]  idx_ff;
   logic           used_rd_ff;
   logic [9:0]     out_idx_ff;
   logic           out_fin_ff, out_exh_ff, out_ovf_ff;
   logic           emit_hit;

   logic [AW-1:0] i_a, jm1_a, j_a, pos_a;
   logic          at_end;
   assign i_a   = i_ff[AW-1:0];
   assign j_a   = j_ff[AW-1:0];
   assign jm1_a = AW'(j_ff - CW'(1));
   assign pos_a = pos_ff[AW-1:0];
   assign at_end = (pos_ff >= count_ff);

   logic signed [KW-1:0] key_rd;
   always_ff @(posedge clock) begin
      if (cmd == CMD_LOAD && !ready_ff && count_ff < CAP) begin
         flux_mem[count_ff[AW-1:0]] <= KW'(flux_in);
         sum_mem[count_ff[AW-1:0]]  <= KW'(flux_in) + KW'(back_in);
      end
      key_rd <= pass_ff ? sum_mem[i_a] : flux_mem[i_a];
   end

   // Rank memories: one write port, one read port each
   logic [AW-1:0] rank_wa, rank_wd, frank_rd, srank_rd, rank_ra;
   logic          rank_we;
   always_comb begin
      rank_we = 1'b0;
      rank_wa = j_a;
      rank_wd = pass_ff ? srank_rd : frank_rd;
      if (cmd == CMD_SORT_SHIFT) begin
         rank_we = 1'b1;
      end else if (cmd == CMD_SORT_PUT) begin
         rank_we = 1'b1;
         rank_wd = i_a;
      end
      rank_ra = (cmd == CMD_EMIT_READ) ? pos_a : jm1_a;
   end
   always_ff @(posedge clock) begin
      if (rank_we && !pass_ff) frank_mem[rank_wa] <= rank_wd;
      if (rank_we && pass_ff)  srank_mem[rank_wa] <= rank_wd;
      frank_rd <= frank_mem[rank_ra];
      srank_rd <= srank_mem[rank_ra];
   end

   // Key of the row at rank j-1, registered in the cycle after the rank read
   logic signed [KW-1:0] cand_rd;
   always_ff @(posedge clock) begin
      cand_rd <= pass_ff ? sum_mem[srank_rd] : flux_mem[frank_rd];
   end

   logic [AW-1:0] used_ra;
   assign used_ra = phase_ff ? srank_rd : frank_rd;
   always_ff @(posedge clock) begin
      if (cmd == CMD_CLEAR_STEP) used_mem[clr_ff] <= 1'b0;
      else if (cmd == CMD_EMIT_DONE && emit_hit) used_mem[idx_ff] <= 1'b1;
      used_rd_ff <= used_mem[used_ra];
   end

   assign emit_hit = live_ff && !used_rd_ff;

   logic ahead;
   assign ahead = asc_ff ? (key_ff < cand_rd) : (key_ff > cand_rd);

   always_ff @(posedge clock) begin
      if (reset || cmd == CMD_NEW) begin
         count_ff    <= '0;
         pos_ff      <= '0;
         emitted_ff  <= '0;
         phase_ff    <= 1'b0;
         ready_ff    <= 1'b0;
         ovf_ff      <= 1'b0;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         pass_ff     <= 1'b0;
         live_ff     <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         asc_ff      <= 1'b0;
      end else begin
         case (cmd)
            CMD_LOAD: begin
               if (!ready_ff) begin
                  if (count_ff < CAP) count_ff <= count_ff + CW'(1);
                  else ovf_ff <= 1'b1;
               end
            end
            CMD_CLEAR_STEP: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_ROWS - 1)) clr_done_ff <= 1'b1;
            end
            CMD_SORT_INIT: begin
               asc_ff  <= cfg_ascending;
               pass_ff <= 1'b0;
               i_ff    <= '0;
               ready_ff <= 1'b1;
            end
            CMD_SORT_READ: j_ff <= i_ff;
            CMD_SORT_CMP: key_ff <= key_rd;
            CMD_SORT_SHIFT: j_ff <= j_ff - CW'(1);
            CMD_SORT_PUT: begin
               if (i_ff + CW'(1) >= count_ff && !pass_ff) begin
                  pass_ff <= 1'b1;
                  i_ff    <= '0;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
            CMD_EMIT_READ: live_ff <= 1'b0;
            CMD_EMIT_CHECK: begin
               idx_ff  <= used_ra;
               live_ff <= !at_end && (used_ra < count_ff[AW-1:0] || count_ff == CAP);
               if (!at_end) begin
                  phase_ff <= !phase_ff;
                  if (phase_ff) pos_ff <= pos_ff + CW'(1);
               end
            end
            CMD_EMIT_DONE: begin
               if (emit_hit) emitted_ff <= emitted_ff + CW'(1);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == CMD_EMIT_DONE) begin
         out_idx_ff <= emit_hit ? 10'(idx_ff) : 10'd0;
         out_fin_ff <= emit_hit && (emitted_ff + CW'(1) == count_ff);
         out_exh_ff <= !emit_hit;
         out_ovf_ff <= ovf_ff;
      end
   end

   logic sort_done;
   assign sort_done = (count_ff == '0) || (pass_ff && i_ff >= count_ff) ||
                      (i_ff >= count_ff);

   assign stat.clear_done  = clr_done_ff;
   assign stat.sort_more   = !sort_done;
   assign stat.sort_done   = sort_done;
   assign stat.shift_go    = (j_ff != '0) && ahead;
   assign stat.emit_hit    = emit_hit;
   assign stat.emit_empty  = !emit_hit && at_end;
   assign stat.ranks_ready = ready_ff;

   assign row_index  = out_idx_ff;
   assign final_row  = out_fin_ff;
   assign exhausted  = out_exh_ff;
   assign overflowed = out_ovf_ff;

   `CHECK_IMPL(a_count_cap, clock, reset, 1'b1, count_ff <= CAP, "row count past capacity")
   `CHECK_IMPL(a_emit_le, clock, reset, 1'b1, emitted_ff <= count_ff, "emitted past count")
   `CHECK_NEXT(a_new_clears, clock, reset, cmd == CMD_NEW, count_ff == '0 && !ready_ff,
               "new table not cleared")
endmodule
